/* hdl/ssdp_pkg.sv */
package ssdp_pkg;

    localparam int MaxStrings = 8;
    localparam int MaxLen     = 8;
    localparam int IdW        = 3;
    localparam int PosW       = 3;
    localparam int LenW       = 4;
    localparam int ChrW       = 8;
    localparam int ActW       = 2;
    localparam int ScoreW     = 7;
    localparam int WtW        = 4;
    localparam int MaskW      = MaxStrings;
    localparam int TextAw     = IdW + PosW;
    localparam int PairAw     = 2 * IdW;
    localparam int ScoreAw    = IdW + MaskW;
    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 8;
    localparam int MaxScore   = (MaxStrings - 1) * MaxLen;

    localparam logic [ActW-1:0] ActWrite = 2'd0;
    localparam logic [ActW-1:0] ActLen   = 2'd1;
    localparam logic [ActW-1:0] ActRun   = 2'd2;

    localparam logic [CfgIdxW-1:0] RegCount = 2'd0;
    localparam logic [CfgIdxW-1:0] RegMode  = 2'd1;
    localparam logic [CfgIdxW-1:0] RegWchar = 2'd2;

    typedef logic [ChrW-1:0] char_t;
    typedef logic [LenW-1:0] len_t;
    typedef logic [IdW-1:0]  id_t;

endpackage

/* hdl/ssdp_ram.sv */
module ssdp_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/shortest_superstring_dp_unit.sv */
// Shortest common superstring engine over up to eight strings of up to eight bytes.
// Input channel (in_valid/in_ready): action 0 stores char_value at (string_id, char_pos),
// action 1 stores string_len (saturated to 8), action 2 starts a run; action 3 is dropped.
// A run is a pairwise overlap pass, a subset/last-string scoring pass, a select and
// backtrack, and the emission of the bytes; the score memory port, which serves one
// read per cycle, sets the pace of the scoring pass.
// in_ready is low during a run. Output channel (out_valid/out_ready) gives one byte per
// transaction; last marks the final one. An empty result is one transaction with has_char
// low and last high. A stalled receiver holds the output register and the run pauses on
// the next byte. Configuration port (cfg_valid/cfg_ready) is always ready; write it only
// while idle. Reset clears lengths to zero and sets string_count 8, weight_mode 0,
// weight_char 0. Text and scratch memories are not cleared.
module shortest_superstring_dp_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ssdp_pkg::ActW-1:0]     action,
    input  logic [ssdp_pkg::IdW-1:0]      string_id,
    input  logic [ssdp_pkg::PosW-1:0]     char_pos,
    input  logic [ssdp_pkg::ChrW-1:0]     char_value,
    input  logic [ssdp_pkg::LenW-1:0]     string_len,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ssdp_pkg::ChrW-1:0]     out_char,
    output logic                          has_char,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ssdp_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [ssdp_pkg::CfgDataW-1:0] cfg_data
);
    import ssdp_pkg::*;

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_OV_LD   = 5'd1;
    localparam logic [4:0] ST_OV_LAST = 5'd2;
    localparam logic [4:0] ST_OV_OV   = 5'd3;
    localparam logic [4:0] ST_OV_WR   = 5'd4;
    localparam logic [4:0] ST_DP_I    = 5'd5;
    localparam logic [4:0] ST_DP_RD   = 5'd6;
    localparam logic [4:0] ST_DP_ACC  = 5'd7;
    localparam logic [4:0] ST_DP_WR   = 5'd8;
    localparam logic [4:0] ST_SEL_RD  = 5'd9;
    localparam logic [4:0] ST_SEL_ACC = 5'd10;
    localparam logic [4:0] ST_BT_ORD  = 5'd11;
    localparam logic [4:0] ST_BT_RD   = 5'd12;
    localparam logic [4:0] ST_BT_ACC  = 5'd13;
    localparam logic [4:0] ST_BT_STEP = 5'd14;
    localparam logic [4:0] ST_EM_STR  = 5'd15;
    localparam logic [4:0] ST_EM_OV   = 5'd16;
    localparam logic [4:0] ST_EM_CHR  = 5'd17;
    localparam logic [4:0] ST_EM_DAT  = 5'd18;
    localparam logic [4:0] ST_EM_END  = 5'd19;

    logic [4:0] state_reg, state_next;

    // configuration
    len_t  count_reg;
    logic  mode_reg;
    char_t wchar_reg;

    len_t  length_reg [MaxStrings];
    id_t   order_reg [MaxStrings];
    char_t row_s_reg [MaxLen];
    char_t row_t_reg [MaxLen];

    id_t              i_reg, j_reg, ind_reg, rdj_reg, jf_reg, bt_k_reg, s_reg;
    logic [MaskW-1:0] mask_reg;
    logic [3:0]       c_reg;
    logic             ld_v_reg;
    logic [3:0]       ld_sel_reg;
    len_t             len_s_reg, len_t_reg;
    logic [WtW-1:0]   ov_reg;
    logic [ScoreW-1:0] best_reg, tnext_reg;
    logic             rdv_reg, first_reg, found_reg;
    len_t             e_cnt_reg, k_reg;
    char_t            pend_reg;
    logic             pend_v_reg;
    logic             out_valid_reg, has_char_reg, last_reg;
    char_t            out_char_reg;

    // memory ports
    logic               text_we;
    logic [TextAw-1:0]  text_raddr;
    char_t              text_rd;
    logic               pair_we;
    logic [PairAw-1:0]  pair_waddr, pair_raddr;
    logic [7:0]         pair_wdata, pair_rd;
    logic               score_we;
    logic [ScoreAw-1:0] score_waddr, score_raddr;
    logic [ScoreW-1:0]  score_rd;

    len_t             n_eff;
    id_t              last_idx;
    logic [MaskW:0]   one_hot_n;
    logic [MaskW-1:0] full_mask, dp_prev, bt_prev;
    logic [7:0]       sum_val;
    logic             slot_free, in_fire, out_fire, cfg_fire;
    id_t              len_sel, s_cur;
    len_t             len_rd, len_min;
    logic [WtW-1:0]   ov_calc, w_calc;
    logic             ok;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign has_char  = has_char_reg;
    assign last      = last_reg;

    assign n_eff     = (count_reg > LenW'(MaxStrings)) ? LenW'(MaxStrings) : count_reg;
    assign last_idx  = IdW'(n_eff - 4'd1);
    assign one_hot_n = (MaskW+1)'(1) << n_eff;
    assign full_mask = MaskW'(one_hot_n - (MaskW+1)'(1));
    assign dp_prev   = mask_reg ^ (MaskW'(1) << i_reg);
    assign bt_prev   = mask_reg ^ (MaskW'(1) << ind_reg);
    assign sum_val   = 8'(score_rd) + 8'(pair_rd[WtW-1:0]);
    assign s_cur     = order_reg[e_cnt_reg[IdW-1:0]];

    assign len_sel = (state_reg == ST_OV_LD) ? (c_reg[3] ? j_reg : i_reg) : s_reg;
    assign len_rd  = length_reg[len_sel];
    assign len_min = (len_s_reg < len_t_reg) ? len_s_reg : len_t_reg;

    // longest suffix of row_s equal to a prefix of row_t; largest match wins
    always_comb
    begin
        ov_calc = '0;
        for (int l = 1; l <= MaxLen; l++)
        begin
            ok = (LenW'(l) <= len_min);
            for (int m = 0; m < MaxLen; m++)
            begin
                if (m < l)
                begin
                    if (row_s_reg[IdW'(len_s_reg - LenW'(l) + LenW'(m))] != row_t_reg[m])
                    begin
                        ok = 1'b0;
                    end
                end
            end
            if (ok)
            begin
                ov_calc = WtW'(l);
            end
        end
    end

    always_comb
    begin
        w_calc = '0;
        for (int m = 0; m < MaxLen; m++)
        begin
            if ((WtW'(m) < ov_reg) && (row_t_reg[m] == wchar_reg))
            begin
                w_calc = w_calc + WtW'(1);
            end
        end
    end

    always_comb
    begin
        text_raddr = {s_reg, k_reg[PosW-1:0]};
        if (state_reg == ST_OV_LD)
        begin
            text_raddr = c_reg[3] ? {j_reg, c_reg[2:0]} : {i_reg, c_reg[2:0]};
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_BT_RD:  pair_raddr = {j_reg, ind_reg};
            ST_EM_STR: pair_raddr = {s_reg, s_cur};
            default:   pair_raddr = {j_reg, i_reg};
        endcase
        case (state_reg)
            ST_SEL_RD: score_raddr = {j_reg, full_mask};
            ST_BT_RD:  score_raddr = {j_reg, bt_prev};
            default:   score_raddr = {j_reg, dp_prev};
        endcase
    end

    assign text_we     = in_fire && (action == ActWrite);
    assign pair_we     = (state_reg == ST_OV_WR);
    assign pair_waddr  = {i_reg, j_reg};
    assign pair_wdata  = {ov_reg, (mode_reg ? w_calc : ov_reg)};
    assign score_we    = (state_reg == ST_DP_WR);
    assign score_waddr = {i_reg, mask_reg};

    ssdp_ram #(.Width(ChrW), .Depth(MaxStrings * MaxLen)) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr ({string_id, char_pos}),
        .wdata (char_value),
        .raddr (text_raddr),
        .rdata (text_rd)
    );

    ssdp_ram #(.Width(8), .Depth(MaxStrings * MaxStrings)) u_pair_ram (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rd)
    );

    ssdp_ram #(.Width(ScoreW), .Depth(MaxStrings << MaskW)) u_score_ram (
        .clk   (clk),
        .we    (score_we),
        .waddr (score_waddr),
        .wdata (best_reg),
        .raddr (score_raddr),
        .rdata (score_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_fire && (action == ActRun))
                begin
                    state_next = (n_eff == '0) ? ST_EM_END : ST_OV_LD;
                end
            ST_OV_LD:
                if (c_reg == 4'd15)
                begin
                    state_next = ST_OV_LAST;
                end
            ST_OV_LAST: state_next = ST_OV_OV;
            ST_OV_OV:   state_next = ST_OV_WR;
            ST_OV_WR:
                state_next = ((j_reg == last_idx) && (i_reg == last_idx)) ? ST_DP_I : ST_OV_LD;
            ST_DP_I:
                if (mask_reg[i_reg])
                begin
                    state_next = ST_DP_RD;
                end
                else if ((i_reg == last_idx) && (mask_reg == full_mask))
                begin
                    state_next = ST_SEL_RD;
                end
            ST_DP_RD:
                if (j_reg == last_idx)
                begin
                    state_next = ST_DP_ACC;
                end
            ST_DP_ACC: state_next = ST_DP_WR;
            ST_DP_WR:
                state_next = ((i_reg == last_idx) && (mask_reg == full_mask)) ? ST_SEL_RD : ST_DP_I;
            ST_SEL_RD:
                if (j_reg == last_idx)
                begin
                    state_next = ST_SEL_ACC;
                end
            ST_SEL_ACC: state_next = ST_BT_ORD;
            ST_BT_ORD:
                state_next = ((bt_prev == '0) || (bt_k_reg == '0)) ? ST_EM_STR : ST_BT_RD;
            ST_BT_RD:
                if (j_reg == last_idx)
                begin
                    state_next = ST_BT_ACC;
                end
            ST_BT_ACC:  state_next = ST_BT_STEP;
            ST_BT_STEP: state_next = found_reg ? ST_BT_ORD : ST_EM_STR;
            ST_EM_STR:
                if (e_cnt_reg == n_eff)
                begin
                    state_next = ST_EM_END;
                end
                else
                begin
                    state_next = (e_cnt_reg == '0) ? ST_EM_CHR : ST_EM_OV;
                end
            ST_EM_OV:  state_next = ST_EM_CHR;
            ST_EM_CHR: state_next = (k_reg < len_rd) ? ST_EM_DAT : ST_EM_STR;
            ST_EM_DAT:
                if (!pend_v_reg || slot_free)
                begin
                    state_next = ST_EM_CHR;
                end
            ST_EM_END:
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    // row buffers and order list hold payload only
    always_ff @(posedge clk)
    begin
        if (ld_v_reg)
        begin
            if (ld_sel_reg[3])
            begin
                row_t_reg[ld_sel_reg[2:0]] <= text_rd;
            end
            else
            begin
                row_s_reg[ld_sel_reg[2:0]] <= text_rd;
            end
        end
        if (state_reg == ST_BT_ORD)
        begin
            order_reg[bt_k_reg] <= ind_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= LenW'(MaxStrings);
            mode_reg      <= 1'b0;
            wchar_reg     <= '0;
            for (int s = 0; s < MaxStrings; s++)
            begin
                length_reg[s] <= '0;
            end
            i_reg         <= '0;
            j_reg         <= '0;
            ind_reg       <= '0;
            rdj_reg       <= '0;
            jf_reg        <= '0;
            bt_k_reg      <= '0;
            s_reg         <= '0;
            mask_reg      <= '0;
            c_reg         <= '0;
            ld_v_reg      <= 1'b0;
            ld_sel_reg    <= '0;
            len_s_reg     <= '0;
            len_t_reg     <= '0;
            ov_reg        <= '0;
            best_reg      <= '0;
            tnext_reg     <= '0;
            rdv_reg       <= 1'b0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            e_cnt_reg     <= '0;
            k_reg         <= '0;
            pend_reg      <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            has_char_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ld_v_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
            rdj_reg   <= j_reg;

            if (cfg_fire)
            begin
                case (cfg_index)
                    RegCount: count_reg <= cfg_data[LenW-1:0];
                    RegMode:  mode_reg  <= cfg_data[0];
                    RegWchar: wchar_reg <= cfg_data;
                    default:  ;
                endcase
            end

            if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            // fold in read data issued last cycle
            if (rdv_reg)
            begin
                case (state_reg)
                    ST_DP_RD, ST_DP_ACC:
                        if (sum_val > 8'(best_reg))
                        begin
                            best_reg <= ScoreW'(sum_val);
                        end
                    ST_SEL_RD, ST_SEL_ACC:
                        if (first_reg || (score_rd > best_reg))
                        begin
                            best_reg  <= score_rd;
                            ind_reg   <= rdj_reg;
                            first_reg <= 1'b0;
                        end
                    ST_BT_RD, ST_BT_ACC:
                        if (!found_reg && (sum_val == 8'(best_reg)))
                        begin
                            found_reg <= 1'b1;
                            jf_reg    <= rdj_reg;
                            tnext_reg <= score_rd;
                        end
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                    if (in_fire)
                    begin
                        if (action == ActLen)
                        begin
                            length_reg[string_id] <= (string_len > LenW'(MaxLen)) ?
                                                     LenW'(MaxLen) : string_len;
                        end
                        else if (action == ActRun)
                        begin
                            i_reg      <= '0;
                            j_reg      <= '0;
                            c_reg      <= '0;
                            pend_v_reg <= 1'b0;
                        end
                    end
                ST_OV_LD:
                begin
                    c_reg      <= c_reg + 4'd1;
                    ld_v_reg   <= 1'b1;
                    ld_sel_reg <= c_reg;
                    if (c_reg == 4'd0)
                    begin
                        len_s_reg <= len_rd;
                    end
                    if (c_reg == 4'd8)
                    begin
                        len_t_reg <= len_rd;
                    end
                end
                ST_OV_OV:
                    ov_reg <= ov_calc;
                ST_OV_WR:
                begin
                    c_reg <= '0;
                    if (j_reg == last_idx)
                    begin
                        j_reg <= '0;
                        i_reg <= (i_reg == last_idx) ? '0 : i_reg + IdW'(1);
                        if (i_reg == last_idx)
                        begin
                            mask_reg <= MaskW'(1);
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + IdW'(1);
                    end
                end
                ST_DP_I, ST_DP_WR:
                    if ((state_reg == ST_DP_I) && mask_reg[i_reg])
                    begin
                        j_reg    <= '0;
                        best_reg <= '0;
                    end
                    else if (i_reg == last_idx)
                    begin
                        i_reg <= '0;
                        if (mask_reg == full_mask)
                        begin
                            j_reg     <= '0;
                            first_reg <= 1'b1;
                        end
                        else
                        begin
                            mask_reg <= mask_reg + MaskW'(1);
                        end
                    end
                    else
                    begin
                        i_reg <= i_reg + IdW'(1);
                    end
                ST_DP_RD:
                begin
                    rdv_reg <= dp_prev[j_reg];
                    j_reg   <= j_reg + IdW'(1);
                end
                ST_SEL_RD:
                begin
                    rdv_reg <= 1'b1;
                    j_reg   <= j_reg + IdW'(1);
                end
                ST_SEL_ACC:
                begin
                    mask_reg <= full_mask;
                    bt_k_reg <= last_idx;
                end
                ST_BT_ORD:
                begin
                    j_reg     <= '0;
                    found_reg <= 1'b0;
                    e_cnt_reg <= '0;
                end
                ST_BT_RD:
                begin
                    rdv_reg <= bt_prev[j_reg];
                    j_reg   <= j_reg + IdW'(1);
                end
                ST_BT_STEP:
                    if (found_reg)
                    begin
                        mask_reg <= bt_prev;
                        ind_reg  <= jf_reg;
                        best_reg <= tnext_reg;
                        bt_k_reg <= bt_k_reg - IdW'(1);
                    end
                ST_EM_STR:
                    if (e_cnt_reg != n_eff)
                    begin
                        s_reg <= s_cur;
                        if (e_cnt_reg == '0)
                        begin
                            k_reg <= '0;
                        end
                    end
                ST_EM_OV:
                    k_reg <= LenW'(pair_rd[7:4]);
                ST_EM_CHR:
                    if (!(k_reg < len_rd))
                    begin
                        e_cnt_reg <= e_cnt_reg + 4'd1;
                    end
                ST_EM_DAT:
                    // one byte held back so the final one can carry last
                    if (!pend_v_reg)
                    begin
                        pend_reg   <= text_rd;
                        pend_v_reg <= 1'b1;
                        k_reg      <= k_reg + 4'd1;
                    end
                    else if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= pend_reg;
                        has_char_reg  <= 1'b1;
                        last_reg      <= 1'b0;
                        pend_reg      <= text_rd;
                        k_reg         <= k_reg + 4'd1;
                    end
                ST_EM_END:
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= pend_v_reg ? pend_reg : '0;
                        has_char_reg  <= pend_v_reg;
                        last_reg      <= 1'b1;
                        pend_v_reg    <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DP_WR) |-> (best_reg <= ScoreW'(MaxScore)))
        else $error("score above bound");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !has_char_reg) |-> last_reg)
        else $error("empty result without last");

    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg |-> (state_reg == ST_EM_STR || state_reg == ST_EM_OV ||
                        state_reg == ST_EM_CHR || state_reg == ST_EM_DAT ||
                        state_reg == ST_EM_END))
        else $error("held byte outside emit");

    a_bt_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BT_ORD) |-> (ind_reg <= last_idx && mask_reg[ind_reg]))
        else $error("backtrack index outside subset");

    a_run_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EM_END && slot_free) |=> (out_valid_reg && last_reg))
        else $error("run ended without final transaction");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
    import ssdp_pkg::*;

    localparam int StallLimit = 200000;
    localparam int DrainCycles = 64;
    localparam logic [ActW-1:0] ActIgnore = 2'd3;

    typedef struct packed {
        char_t ch;
        logic  has;
        logic  lst;
    } sstr_byte_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [ActW-1:0]     action;
    id_t                 string_id;
    logic [PosW-1:0]     char_pos;
    char_t               char_value;
    len_t                string_len;
    logic                out_valid;
    logic                out_ready;
    char_t               out_char;
    logic                has_char;
    logic                last;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    shortest_superstring_dp_unit u_top (.*);

    // shadow state of the block
    char_t      text_mem [MaxStrings*MaxLen];
    bit         text_known [MaxStrings*MaxLen];
    int         len_mem [MaxStrings];
    int         order_mem [MaxStrings];
    int         num_strings;
    int         wmode;
    int         wchar;
    sstr_byte_t superstring_q [$];

    int  error_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    int  quiet_cycles;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pair_overlap(int s, int t);
        int ls;
        int lt;
        int n;
        bit ok;
        ls = len_mem[s];
        lt = len_mem[t];
        n = (ls < lt) ? ls : lt;
        forever begin
            ok = 1'b1;
            for (int k = 0; k < n; k++)
                if (text_mem[s*MaxLen + ls - n + k] != text_mem[t*MaxLen + k])
                    ok = 1'b0;
            if (ok || n == 0)
                return n;
            n--;
        end
    endfunction

    function automatic void predict_superstring();
        int n;
        int full;
        int ind;
        int mask;
        int prev;
        int best;
        int v;
        int j;
        int k;
        int from;
        int total;
        int s;
        int ovl [MaxStrings][MaxStrings];
        int wt [MaxStrings][MaxStrings];
        int best_tbl [MaxStrings][1<<MaxStrings];
        sstr_byte_t b;
        n = (num_strings > MaxStrings) ? MaxStrings : num_strings;
        total = 0;
        if (n > 0) begin
            full = (1 << n) - 1;
            for (int i = 0; i < n; i++)
                for (int jj = 0; jj < n; jj++) begin
                    ovl[i][jj] = pair_overlap(i, jj);
                    v = 0;
                    for (int kk = 0; kk < ovl[i][jj]; kk++)
                        if (text_mem[jj*MaxLen + kk] == char_t'(wchar))
                            v++;
                    wt[i][jj] = wmode ? v : ovl[i][jj];
                end
            for (int m = 1; m <= full; m++)
                for (int i = 0; i < n; i++) begin
                    if (m[i]) begin
                        prev = m ^ (1 << i);
                        best = 0;
                        for (int jj = 0; jj < n; jj++)
                            if (prev[jj] && best_tbl[jj][prev] + wt[jj][i] > best)
                                best = best_tbl[jj][prev] + wt[jj][i];
                        best_tbl[i][m] = best;
                    end
                end
            ind = 0;
            for (int i = 1; i < n; i++)
                if (best_tbl[i][full] > best_tbl[ind][full])
                    ind = i;
            mask = full;
            k = n;
            forever begin
                k--;
                order_mem[k] = ind;
                prev = mask ^ (1 << ind);
                if (prev == 0 || k == 0)
                    break;
                j = 0;
                while (j < n && !(prev[j] &&
                       best_tbl[j][prev] + wt[j][ind] == best_tbl[ind][mask]))
                    j++;
                if (j >= n)
                    break;
                mask = prev;
                ind = j;
            end
            for (int i = 0; i < n; i++) begin
                s = order_mem[i];
                from = (i == 0) ? 0 : ovl[order_mem[i-1]][s];
                for (int kk = from; kk < len_mem[s]; kk++) begin
                    b.ch = text_mem[s*MaxLen + kk];
                    b.has = 1'b1;
                    b.lst = 1'b0;
                    superstring_q.push_back(b);
                    total++;
                end
            end
        end
        if (total == 0) begin
            b.ch = '0;
            b.has = 1'b0;
            b.lst = 1'b1;
            superstring_q.push_back(b);
        end else begin
            b = superstring_q[$];
            b.lst = 1'b1;
            superstring_q[$] = b;
        end
    endfunction

    // called at a clock edge; returns at the edge where the transaction is taken
    task automatic send_item(logic [ActW-1:0] act, int id, int pos, int val, int len);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        action     <= act;
        string_id  <= id_t'(id);
        char_pos   <= PosW'(pos);
        char_value <= char_t'(val);
        string_len <= len_t'(len);
        do
            @(posedge clk);
        while (!in_ready);
        case (act)
            ActWrite: begin
                text_mem[id*MaxLen + pos] = char_t'(val);
                text_known[id*MaxLen + pos] = 1'b1;
            end
            ActLen: len_mem[id] = (len > MaxLen) ? MaxLen : len;
            ActRun: predict_superstring();
            default: ;
        endcase
    endtask

    function automatic int pick_char();
        // small alphabet so strings overlap often
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'h61;
            4, 5, 6:    return 8'h62;
            7:          return wchar;
            default:    return $urandom_range(255);
        endcase
    endfunction

    task automatic put_char(int id, int pos, int val);
        send_item(ActWrite, id, pos, val, $urandom_range(15));
    endtask

    // fills any unwritten prefix first so no run ever reads unknown text
    task automatic put_len(int id, int len);
        int eff;
        eff = (len > MaxLen) ? MaxLen : len;
        for (int p = 0; p < eff; p++)
            if (!text_known[id*MaxLen + p])
                put_char(id, p, pick_char());
        send_item(ActLen, id, $urandom_range(7), $urandom_range(255), len);
    endtask

    task automatic run_item();
        send_item(ActRun, $urandom_range(7), $urandom_range(7), $urandom_range(255),
                  $urandom_range(15));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (superstring_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CfgDataW'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            RegCount: num_strings = data & 4'hF;
            RegMode:  wmode = data & 1;
            RegWchar: wchar = data & 8'hFF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // receiver
    always @(posedge clk) begin
        if (recv_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        sstr_byte_t exp_b;
        if (rst_n && out_valid && out_ready) begin
            if (superstring_q.size() == 0) begin
                $error("unexpected output transaction: out_char %0h", out_char);
                error_count++;
            end else begin
                exp_b = superstring_q.pop_front();
                if (out_char !== exp_b.ch) begin
                    $error("out_char: expected %0h, got %0h", exp_b.ch, out_char);
                    error_count++;
                end
                if (has_char !== exp_b.has) begin
                    $error("has_char: expected %0b, got %0b", exp_b.has, has_char);
                    error_count++;
                end
                if (last !== exp_b.lst) begin
                    $error("last: expected %0b, got %0b", exp_b.lst, last);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        run_item();                       // all lengths zero: empty result
        put_char(0, 0, 8'h00);
        put_char(0, 1, 8'hFF);
        put_len(0, 2);
        put_char(1, 0, 8'hFF);
        put_char(1, 1, 8'h00);
        put_len(1, 2);
        put_len(2, 15);                   // saturates to full length
        send_item(ActIgnore, 7, 7, 8'hFF, 15); // unknown action, dropped
        run_item();
        write_reg(RegCount, 0);
        run_item();                       // no strings: empty result
        write_reg(RegCount, 15);
        run_item();
        write_reg(RegCount, 1);
        run_item();
        write_reg(RegMode, 1);
        write_reg(RegWchar, 8'hFF);
        write_reg(RegCount, 3);
        run_item();
        write_reg(RegWchar, 8'h61);
        run_item();
    endtask

    task automatic test_random_phase(int idle, int stall, int items);
        int r;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(99);
            if (r < 40)
                put_char($urandom_range(7), $urandom_range(7), pick_char());
            else if (r < 70)
                put_len($urandom_range(7), ($urandom_range(9) == 0) ?
                        $urandom_range(15) : $urandom_range(8));
            else if (r < 74)
                send_item(ActIgnore, $urandom_range(7), $urandom_range(7),
                          $urandom_range(255), $urandom_range(15));
            else begin
                if ($urandom_range(2) == 0) begin
                    write_reg(RegCount, ($urandom_range(7) == 0) ? 8 : $urandom_range(1, 5));
                    write_reg(RegMode, $urandom_range(1));
                    write_reg(RegWchar, pick_char());
                end
                run_item();
            end
        end
    endtask

    task automatic test_backpressure();
        write_reg(RegCount, 4);
        write_reg(RegMode, 0);
        fork
            begin
                recv_hold = 1'b1;
                repeat (3000) @(posedge clk);
                recv_hold = 1'b0;
            end
        join_none
        run_item();
        put_char(3, 0, pick_char());
        run_item();
        put_len(3, 8);
        run_item();
        wait_idle();                      // sender waits for everything to drain
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ActWrite;
        string_id = '0;
        char_pos = '0;
        char_value = '0;
        string_len = '0;
        cfg_valid = 1'b0;
        cfg_index = RegCount;
        cfg_data = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b0;
        num_strings = MaxStrings;
        wmode = 0;
        wchar = 0;
        for (int i = 0; i < MaxStrings*MaxLen; i++) begin
            text_mem[i] = '0;
            text_known[i] = 1'b0;
        end
        for (int i = 0; i < MaxStrings; i++) begin
            len_mem[i] = 0;
            order_mem[i] = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(0, 0, 15);
        test_random_phase(45, 0, 15);
        test_random_phase(0, 45, 15);
        test_random_phase(19, 19, 15);
        test_backpressure();
        write_reg(RegCount, 8);           // one full-size run
        write_reg(RegMode, 1);
        write_reg(RegWchar, 8'h62);
        run_item();

        wait_idle();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
